FILE: rtl/swmv_pkg.sv
// Shared constants and types of the sliding-window mean and variance block.
package swmv_pkg;
    localparam int WindowMax = 256;
    localparam int IdxW = $clog2(WindowMax);
    localparam int CntW = IdxW + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MEAN, S_RESN, S_SQN, S_SSE, S_VAR, S_CHG, S_SQM, S_SQV, S_OUT
    } t_state;
endpackage

FILE: rtl/swmv_div.sv
// Iterative restoring divider: 64-bit unsigned dividend by 9-bit divisor, one bit a cycle.
module swmv_div
    import swmv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [8:0]  i_divisor,
    output logic        o_busy,
    output logic [63:0] o_quotient
);
    logic [63:0] r_q, n_q;
    logic [9:0]  r_rem, n_rem;
    logic [6:0]  r_cnt, n_cnt;
    logic [8:0]  r_div;
    logic [9:0]  w_sh;

    always_comb begin
        w_sh  = {r_rem[8:0], r_q[63]};
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_sh;
        n_cnt = r_cnt;
        if (r_cnt != 7'd0) begin
            n_cnt = r_cnt - 7'd1;
            if (w_sh >= {1'b0, r_div}) begin
                n_rem = w_sh - {1'b0, r_div};
                n_q[0] = 1'b1;
            end
        end else begin
            n_q   = r_q;
            n_rem = r_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'd64;
        end else begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy     = (r_cnt != 7'd0);
    assign o_quotient = r_q;
endmodule

FILE: rtl/sliding_window_mean_variance.sv
// Top level of the sliding-window running mean and variance block.
//  channel  | dir | handshake               | payload
//  s_axis   | in  | i_s_axis_tvalid/tready  | tdata[15:0] sample
//  m_axis   | out | o_m_axis_tvalid/tready  | tdata: mean, variance, mean_change,
//           |     |                         |   variance_change, settle_error,
//           |     |                         |   sample_count, window_full
//  cfg      | in  | i_cfg_we                | i_cfg_wdata[8:0] window_len
// Each word passes twice through the shared divider and four times through the shared
// 32x32 multiplier; no new word is accepted until its result reaches the output stage.
// Reset is synchronous and active low; the window memory needs no clearing.
// A held result stalls the next word only when that word reaches the output stage first.
module sliding_window_mean_variance
    import swmv_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [15:0]  i_s_axis_tdata,   // sample
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // mean[31:0], variance[79:32], mean_change[113:80], variance_change[163:114],
    // settle_error[227:164], sample_count[236:228], window_full[237], zero fill
    output logic [239:0] o_m_axis_tdata,
    input  logic         i_cfg_we,
    input  logic [8:0]   i_cfg_wdata
);
    t_state r_state, n_state;
    logic [8:0]  r_len;
    logic [15:0] r_mem [WindowMax];
    logic signed [15:0] r_x, r_old;
    logic [CntW-1:0] r_fill, r_oldest;
    logic signed [23:0] r_sum;
    logic signed [63:0] r_sse;
    logic signed [31:0] r_pmean, r_mean;
    logic [47:0] r_pvar, r_var;
    logic signed [63:0] r_resn;
    logic signed [33:0] r_dm;
    logic signed [49:0] r_dv;
    logic [63:0] r_err;
    logic        r_full, r_ovalid;
    logic [239:0] r_out;
    logic [CntW-1:0] w_len;
    logic        w_filling;
    logic        d_start;
    logic [63:0] d_dvd, d_q;
    logic        d_busy;
    logic        r_go;
    logic signed [23:0] w_sum;
    logic signed [63:0] w_num;
    logic [63:0] w_mag, w_abs;
    logic        w_neg;
    logic [63:0] w_sq;
    logic signed [16:0] w_dsum;
    logic signed [63:0] w_res0;
    logic [2:0]  r_step;
    logic        w_mul_st, w_mlast;
    logic [16:0] w_dmag;
    logic [39:0] w_ma, w_mb;
    logic [31:0] w_pa, w_pb;
    logic [63:0] w_pp;
    logic [79:0] r_macc, w_macc;
    logic        w_sat, w_pneg;
    logic signed [63:0] w_term, w_ssev;
    logic [64:0] w_esum;
    logic        w_out_load;

    assign w_len = (r_len == 9'd0) ? CntW'(1) :
                   (r_len > 9'(WindowMax)) ? CntW'(WindowMax) : CntW'(r_len);
    assign w_filling = (r_fill < w_len);

    assign w_sum = (r_state == S_MEAN && !r_go && r_full) ? r_sum + 24'(w_dsum) : r_sum;
    assign w_num = 64'(w_sum) <<< 16;
    assign w_neg = w_num[63];
    assign w_mag = w_neg ? -w_num : w_num;
    assign d_start = (r_state == S_MEAN || r_state == S_VAR) && !r_go;
    assign d_dvd = (r_state == S_MEAN) ? w_mag : r_sse;

    swmv_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start),
        .i_dividend(d_dvd), .i_divisor(r_fill), .o_busy(d_busy), .o_quotient(d_q)
    );

    always_comb begin
        w_abs = r_resn[63] ? 64'(-r_resn) : 64'(r_resn);
        case (r_state)
            S_SQM:   w_abs = r_dm[33] ? 64'(-r_dm) : 64'(r_dm);
            S_SQV:   w_abs = r_dv[49] ? 64'(-r_dv) : 64'(r_dv);
            default: ;
        endcase
    end
    assign w_dsum = 17'(r_x) - 17'(r_old);
    assign w_res0 = (64'(r_old) <<< 16) - 64'(r_pmean);

    // A 40 by 40 product is built from four 32 by 32 partial products, one per cycle.
    assign w_mul_st = (r_state == S_SQN) || (r_state == S_SSE) ||
                      (r_state == S_SQM) || (r_state == S_SQV);
    assign w_mlast = (r_step == 3'd4);
    assign w_dmag = w_dsum[16] ? 17'(-w_dsum) : 17'(w_dsum);
    assign w_ma = w_abs[39:0];
    assign w_mb = (r_state == S_SSE) ? 40'(w_dmag) : w_abs[39:0];

    always_comb begin
        w_pa = w_ma[31:0];
        w_pb = w_mb[31:0];
        case (r_step)
            3'd0: ;
            3'd1: w_pb = 32'(w_mb[39:32]);
            3'd2: w_pa = 32'(w_ma[39:32]);
            default: begin
                w_pa = 32'(w_ma[39:32]);
                w_pb = 32'(w_mb[39:32]);
            end
        endcase
    end
    assign w_pp = w_pa * w_pb;

    always_comb begin
        case (r_step)
            3'd0:       w_macc = 80'(w_pp);
            3'd1, 3'd2: w_macc = r_macc + (80'(w_pp) << 32);
            3'd3:       w_macc = r_macc + (80'(w_pp) << 64);
            default:    w_macc = r_macc;
        endcase
    end

    // Squares saturate once the operand reaches 2^40.
    assign w_sat = (w_abs[63:40] != '0);
    assign w_sq = w_sat ? '1 : r_macc[79:16];
    assign w_pneg = w_dsum[16] ^ r_resn[63];
    assign w_term = !r_full ? r_resn :
                    w_pneg ? -$signed(r_macc[63:0]) : $signed(r_macc[63:0]);
    assign w_ssev = r_sse + w_term;
    assign w_esum = {1'b0, r_err} + {1'b0, w_sq};

    assign w_out_load = (r_state == S_OUT) && (!r_ovalid || i_m_axis_tready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_s_axis_tvalid) n_state = S_READ;
            S_READ: n_state = S_MEAN;
            S_MEAN: if (r_go && !d_busy) n_state = S_RESN;
            S_RESN: n_state = S_SQN;
            S_SQN:  if (w_mlast) n_state = S_SSE;
            S_SSE:  if (w_mlast) n_state = S_VAR;
            S_VAR:  if (r_go && !d_busy) n_state = S_CHG;
            S_CHG:  n_state = S_SQM;
            S_SQM:  if (w_mlast) n_state = S_SQV;
            S_SQV:  if (w_mlast) n_state = S_OUT;
            S_OUT:  if (!r_ovalid || i_m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_len <= 9'd256; r_ovalid <= 1'b0; r_go <= 1'b0;
            r_fill <= '0; r_oldest <= '0; r_sum <= '0; r_sse <= '0;
            r_pmean <= '0; r_pvar <= '0; r_step <= '0;
        end else if (i_cfg_we) begin
            r_len <= i_cfg_wdata; r_state <= S_IDLE; r_go <= 1'b0;
            r_fill <= '0; r_oldest <= '0; r_sum <= '0; r_sse <= '0;
            r_pmean <= '0; r_pvar <= '0; r_step <= '0;
        end else begin
            r_state <= n_state;
            r_go <= d_start ? 1'b1 : ((n_state != r_state) ? 1'b0 : r_go);
            r_step <= (w_mul_st && !w_mlast) ? r_step + 3'd1 : 3'd0;
            r_macc <= w_macc;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (i_m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_s_axis_tready && i_s_axis_tvalid) r_x <= i_s_axis_tdata;
                S_READ: begin
                    r_full <= !w_filling;
                    if (w_filling) begin
                        r_mem[r_fill[IdxW-1:0]] <= r_x;
                        r_fill <= r_fill + CntW'(1);
                        r_sum <= r_sum + 24'(r_x);
                        r_old <= '0;
                    end else begin
                        r_old <= (r_oldest >= w_len) ? r_mem[0] : r_mem[r_oldest[IdxW-1:0]];
                        if (r_oldest >= w_len) r_oldest <= '0;
                    end
                end
                S_MEAN: if (!r_go && r_full) begin
                    r_sum <= w_sum;
                end else if (r_go && !d_busy) begin
                    r_mean <= w_neg ? -32'(d_q) : 32'(d_q);
                end
                S_RESN: r_resn <= (64'(r_x) <<< 16) - 64'(r_mean);
                S_SQN: if (w_mlast) begin
                    if (r_full) r_resn <= r_resn + w_res0;
                    else r_resn <= 64'(w_sq);
                end
                S_SSE: if (w_mlast) begin
                    if (w_ssev < 0) r_sse <= '0;
                    else if (w_ssev > 64'sh00FF_FFFF_FFFF_FFFF) r_sse <= 64'sh00FF_FFFF_FFFF_FFFF;
                    else r_sse <= w_ssev;
                    if (r_full) begin
                        r_mem[r_oldest[IdxW-1:0]] <= r_x;
                        r_oldest <= r_oldest + CntW'(1);
                    end
                end
                S_VAR: if (r_go && !d_busy)
                    r_var <= (d_q[63:48] != '0) ? '1 : d_q[47:0];
                S_CHG: begin
                    r_dm <= 34'(r_mean) - 34'(r_pmean);
                    r_dv <= 50'(r_var) - 50'(r_pvar);
                end
                S_SQM: if (w_mlast) r_err <= w_sq;
                S_SQV: if (w_mlast) r_err <= w_esum[64] ? '1 : w_esum[63:0];
                S_OUT: if (w_out_load) begin
                    r_out <= {2'b00, (r_fill >= w_len), 9'(r_fill), r_err,
                              r_dv, r_dm, r_var, r_mean};
                    r_pmean <= r_mean;
                    r_pvar <= r_var;
                end
                default: ;
            endcase
        end
    end
endmodule
